[hw/rtl/npv_pkg.sv]
// shared constants, codes and types of the note pair validator
`timescale 1ns / 1ps

package npv_pkg;

  // sizing of the open-note store
  localparam int COUNT_WIDTH = 16;
  localparam int GROUP_COUNT = 16;
  localparam int CHANNELS    = 16;
  localparam int NOTES       = 128;
  localparam int ENTRIES     = GROUP_COUNT * CHANNELS * NOTES;
  localparam int INDEX_W     = $clog2(ENTRIES);

  // reported totals are 32 bits; the open sum is kept exact and wide enough
  // to always carry a bit above the reported width
  localparam int TOTAL_W = 32;
  localparam int OPEN_W  = (COUNT_WIDTH + INDEX_W > TOTAL_W) ?
                           (COUNT_WIDTH + INDEX_W) : (TOTAL_W + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [INDEX_W-1:0]     index_t;

  localparam count_t COUNT_MAX = '1;

  // event classes
  typedef enum logic [1:0] {
    OP_OTHER    = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_REPORT   = 2'd3
  } op_t;

  // updates sent to the totals unit
  typedef struct packed {
    logic open_inc;
    logic open_dec;
    logic off_inc;
    logic clear;
  } tally_ctrl_t;

endpackage

[hw/rtl/npv_count_ram.sv]
// single-port-write, registered-read memory holding the open-note counts
`timescale 1ns / 1ps

module npv_count_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/npv_tally.sv]
// running open-note and unmatched note-off totals with report saturation
`timescale 1ns / 1ps

module npv_tally (
  input  logic                 clk,
  input  logic                 rst,
  input  npv_pkg::tally_ctrl_t ctrl,
  output logic [31:0]          ons_sat,
  output logic [31:0]          offs
);
  import npv_pkg::*;

  logic [OPEN_W-1:0]  open_total;
  logic [TOTAL_W-1:0] off_total;

  // totals update, cleared by reset or a report
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      open_total <= '0;
      off_total  <= '0;
    end else begin
      if (ctrl.open_inc) begin
        open_total <= open_total + OPEN_W'(1);
      end else if (ctrl.open_dec) begin
        open_total <= open_total - OPEN_W'(1);
      end
      if (ctrl.off_inc && (off_total != '1)) begin
        off_total <= off_total + TOTAL_W'(1);
      end
    end
  end

  // open sum clamps to the reported width
  assign ons_sat = (|open_total[OPEN_W-1:TOTAL_W]) ? '1 : open_total[TOTAL_W-1:0];
  assign offs    = off_total;

endmodule

[hw/rtl/note_pair_validator_top.sv]
// top level of the note pair validator: event pipeline, store clear and report
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, operation, group,          | in
//          | channel, note                                  |
//  output  | out_valid, out_stall, open_notes,              | out
//          | orphan_offs, pairs_ok                          |
//
// one event per cycle while in_stall is low: the store is read when a request is
// taken and written back the next cycle, with the last write forwarded to a following hit.
// after reset and after every report the store is cleared one entry a cycle,
// all ENTRIES entries (32768 as built), while the input stalls.
// a report waiting at the output stalls only a following report request.
`timescale 1ns / 1ps

module note_pair_validator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  group,
  input  logic [3:0]  channel,
  input  logic [6:0]  note,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] open_notes,
  output logic [31:0] orphan_offs,
  output logic        pairs_ok
);
  import npv_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_CLEAR = 2'b10
  } state_t;

  state_t      state;
  index_t      clear_index;
  op_t         in_op;
  logic        in_accept;
  logic        group_ok;
  logic        keep;
  logic [18:0] event_index_full;
  index_t      event_index;

  logic        s1_valid;
  op_t         s1_op;
  index_t      s1_index;
  logic        s1_report;

  logic        fwd_valid;
  index_t      fwd_index;
  count_t      fwd_count;

  count_t      rdata;
  count_t      cur_count;
  logic        upd_we;
  count_t      upd_count;
  tally_ctrl_t ctrl;

  logic        ram_we;
  index_t      ram_waddr;
  count_t      ram_wdata;

  logic [31:0] ons_sat;
  logic [31:0] offs;

  // request decode
  assign in_op            = op_t'(operation);
  assign group_ok         = group < 8'(GROUP_COUNT);
  assign keep             = (in_op == OP_REPORT) ||
                            (((in_op == OP_NOTE_ON) || (in_op == OP_NOTE_OFF)) && group_ok);
  assign event_index_full = {group, channel, note};
  assign event_index      = event_index_full[INDEX_W-1:0];
  assign s1_report        = s1_valid && (s1_op == OP_REPORT);

  // hold off during clearing, behind a report, or when a report would overrun
  assign in_stall  = (state == ST_CLEAR) || s1_report ||
                     (out_valid && (in_op == OP_REPORT));
  assign in_accept = in_valid && !in_stall;

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op    <= in_op;
      s1_index <= event_index;
    end
  end

  // last written count bypasses the memory for a back-to-back hit
  assign cur_count = (fwd_valid && (fwd_index == s1_index)) ? fwd_count : rdata;

  // modify step
  always_comb begin
    upd_we        = 1'b0;
    upd_count     = cur_count;
    ctrl          = '0;
    ctrl.clear    = s1_report;
    if (s1_valid) begin
      unique case (s1_op)
        OP_NOTE_ON: begin
          if (cur_count != COUNT_MAX) begin
            upd_we        = 1'b1;
            upd_count     = cur_count + COUNT_WIDTH'(1);
            ctrl.open_inc = 1'b1;
          end
        end
        OP_NOTE_OFF: begin
          if (cur_count != '0) begin
            upd_we        = 1'b1;
            upd_count     = cur_count - COUNT_WIDTH'(1);
            ctrl.open_dec = 1'b1;
          end else begin
            ctrl.off_inc  = 1'b1;
          end
        end
        OP_REPORT, OP_OTHER: begin
        end
        default: begin
        end
      endcase
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= upd_we;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      fwd_index <= s1_index;
      fwd_count <= upd_count;
    end
  end

  // write port: clear sweep or write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_index;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_index;
      ram_wdata = upd_count;
    end
  end

  npv_count_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (INDEX_W),
    .DATA_W (COUNT_WIDTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept && keep),
    .raddr (event_index),
    .rdata (rdata)
  );

  npv_tally u_tally (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .ons_sat (ons_sat),
    .offs    (offs)
  );

  // clear sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_index <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (s1_report) begin
            state       <= ST_CLEAR;
            clear_index <= '0;
          end
        end
        ST_CLEAR: begin
          if (clear_index == INDEX_W'(ENTRIES - 1)) begin
            state <= ST_RUN;
          end else begin
            clear_index <= clear_index + INDEX_W'(1);
          end
        end
        default: begin
          state       <= ST_CLEAR;
          clear_index <= '0;
        end
      endcase
    end
  end

  // report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_report) begin
      open_notes  <= ons_sat;
      orphan_offs <= offs;
      pairs_ok    <= (ons_sat == '0) && (offs == '0);
    end
  end

endmodule

[verif/note_pair_validator_top_test.sv]
// testbench for note_pair_validator_top: directed and random clips against a behavioral model
`timescale 1ns / 1ps

module note_pair_validator_top_test;
  import npv_pkg::*;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLDOFF_LEN  = 36000;
  localparam int CLIP_COUNT   = 20;
  localparam int REPEAT_HITS  = 40;

  typedef struct {
    logic [31:0] ons;
    logic [31:0] offs;
    logic        ok;
  } report_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  ev_op = OP_OTHER;
  logic [7:0]  ev_group = '0;
  logic [3:0]  ev_channel = '0;
  logic [6:0]  ev_note = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] open_notes;
  logic [31:0] orphan_offs;
  logic        pairs_ok;

  // model state: open count per key, exact open sum, unmatched note-off total
  int unsigned open_counts [int unsigned];
  logic [63:0] open_sum = '0;
  logic [31:0] stray_offs = '0;
  report_t     expected_reports [$];

  int          errors = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  rx_mode_t    rx_mode = RX_FREE;
  int          holdoff_req = 0;
  int          hold_left = 0;
  logic [7:0]  stall_pattern = 8'b1011_0010;

  note_pair_validator_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (ev_op),
    .group       (ev_group),
    .channel     (ev_channel),
    .note        (ev_note),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .open_notes  (open_notes),
    .orphan_offs (orphan_offs),
    .pairs_ok    (pairs_ok)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // update the pair tallies for one accepted request
  task automatic tally_event(op_t op, logic [7:0] grp, logic [3:0] ch, logic [6:0] nt);
    int unsigned key;
    int unsigned cnt;
    report_t     rep;
    if (op == OP_REPORT) begin
      rep.ons  = (open_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : open_sum[31:0];
      rep.offs = stray_offs;
      rep.ok   = (rep.ons == 0 && rep.offs == 0);
      expected_reports.insert(expected_reports.size(), rep);
      open_counts.delete();
      open_sum   = '0;
      stray_offs = '0;
    end else if (op != OP_OTHER && grp < GROUP_COUNT) begin
      key = (grp * CHANNELS + ch) * NOTES + nt;
      cnt = open_counts.exists(key) ? open_counts[key] : 0;
      if (op == OP_NOTE_ON) begin
        if (cnt < COUNT_MAX) begin
          open_counts[key] = cnt + 1;
          open_sum++;
        end
      end else if (cnt > 0) begin
        open_counts[key] = cnt - 1;
        open_sum--;
      end else if (stray_offs != 32'hFFFF_FFFF) begin
        stray_offs++;
      end
    end
  endtask

  // offer one request, in bursts with gaps, and tally it once taken
  task automatic send_event(op_t op, logic [7:0] grp, logic [3:0] ch, logic [6:0] nt);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid   <= 1'b1;
    ev_op      <= op;
    ev_group   <= grp;
    ev_channel <= ch;
    ev_note    <= nt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tally_event(op, grp, ch, nt);
    if (burst_left > 0) burst_left--;
  endtask

  // report with random don't-care fields
  task automatic send_report();
    send_event(OP_REPORT, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               7'($urandom_range(0, 127)));
  endtask

  // hold the input idle until every report has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // receiver stall: long hold-off when asked, else the current mode
  always @(posedge clk) begin
    if (holdoff_req != 0) begin
      hold_left   = holdoff_req;
      holdoff_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        RX_PATTERN: out_stall <= stall_pattern[0];
        default:    out_stall <= 1'b0;
      endcase
    end
    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each report taken with the oldest expected one
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report expected none actual ons %0d offs %0d ok %0d",
                 $time, open_notes, orphan_offs, pairs_ok);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("open_notes", want.ons, open_notes);
        check_field("orphan_offs", want.offs, orphan_offs);
        check_field("pairs_ok", 32'(want.ok), 32'(pairs_ok));
      end
    end
  end

  // matched pairs, stray offs, ignored and skipped events, back-to-back reports
  task automatic test_pairing_basics();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    send_event(OP_NOTE_ON, 8'd0, 4'd0, 7'd0);
    send_event(OP_NOTE_OFF, 8'd0, 4'd0, 7'd0);
    send_event(OP_NOTE_OFF, 8'd15, 4'd15, 7'd127);
    send_event(OP_OTHER, 8'd0, 4'd0, 7'd0);
    send_event(OP_OTHER, 8'd255, 4'd15, 7'd127);
    send_event(OP_NOTE_ON, 8'd16, 4'd1, 7'd1);
    send_event(OP_NOTE_ON, 8'd255, 4'd15, 7'd127);
    send_event(OP_NOTE_OFF, 8'd200, 4'd5, 7'd5);
    send_event(OP_NOTE_ON, 8'd15, 4'd15, 7'd127);
    send_event(OP_NOTE_ON, 8'd15, 4'd15, 7'd127);
    send_event(OP_NOTE_ON, 8'd3, 4'd7, 7'd64);
    send_event(OP_NOTE_OFF, 8'd3, 4'd7, 7'd64);
    send_event(OP_NOTE_OFF, 8'd3, 4'd7, 7'd64);
    send_event(OP_NOTE_ON, 8'd0, 4'd15, 7'd0);
    send_event(OP_NOTE_ON, 8'd15, 4'd0, 7'd127);
    send_event(OP_NOTE_OFF, 8'd0, 4'd15, 7'd0);
    send_event(OP_NOTE_OFF, 8'd15, 4'd0, 7'd127);
    send_event(OP_REPORT, 8'd255, 4'd15, 7'd127);
    send_event(OP_REPORT, 8'd0, 4'd0, 7'd0);
    // store must be empty after the reports
    send_event(OP_NOTE_OFF, 8'd15, 4'd15, 7'd127);
    send_report();
    wait_drained();
  endtask

  // hit one entry back to back so its updates after the first go through the bypass
  task automatic test_entry_repeat_hits();
    logic [7:0] grp;
    logic [3:0] ch;
    logic [6:0] nt;
    grp = 8'($urandom_range(0, GROUP_COUNT - 1));
    ch  = 4'($urandom_range(0, 15));
    nt  = 7'($urandom_range(0, 127));
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    repeat (REPEAT_HITS) send_event(OP_NOTE_ON, grp, ch, nt);
    send_event(OP_NOTE_OFF, grp, ch, nt);
    send_event(OP_NOTE_ON, grp, ch, nt);
    send_event(OP_NOTE_ON, grp, ch ^ 4'd1, nt);
    send_report();
    wait_drained();
  endtask

  // long receiver hold-off while reports and events keep coming
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_FREE;
    holdoff_req = HOLDOFF_LEN;
    send_event(OP_NOTE_ON, 8'd1, 4'd2, 7'd3);
    send_report();
    send_event(OP_NOTE_ON, 8'd4, 4'd5, 7'd6);
    send_event(OP_NOTE_OFF, 8'd4, 4'd5, 7'd7);
    send_report();
    send_event(OP_NOTE_OFF, 8'd9, 4'd9, 7'd9);
    send_event(OP_NOTE_ON, 8'd9, 4'd9, 7'd9);
    send_report();
    wait_drained();
  endtask

  // random clips: mostly well-formed pairing on a small key pool, some noise
  task automatic test_random_clips();
    logic [7:0] pool_g [4];
    logic [3:0] pool_c [4];
    logic [6:0] pool_n [4];
    int         open_keys [$];
    int         len;
    int         pick;
    int         roll;
    for (int clip = 0; clip < CLIP_COUNT; clip++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      open_keys.delete();
      for (int k = 0; k < 4; k++) begin
        pool_g[k] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(16, 255))
                                                : 8'($urandom_range(0, GROUP_COUNT - 1));
        pool_c[k] = 4'($urandom_range(0, 15));
        pool_n[k] = 7'($urandom_range(0, 127));
      end
      len = $urandom_range(8, 32);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          send_event(op_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
        end else if (roll < 14) begin
          pick = $urandom_range(0, 3);
          send_event(OP_NOTE_OFF, pool_g[pick], pool_c[pick], pool_n[pick]);
        end else if (roll < 50 && open_keys.size() > 0) begin
          pick = $urandom_range(0, open_keys.size() - 1);
          send_event(OP_NOTE_OFF, pool_g[open_keys[pick]], pool_c[open_keys[pick]],
                     pool_n[open_keys[pick]]);
          open_keys.delete(pick);
        end else begin
          pick = $urandom_range(0, 3);
          send_event(OP_NOTE_ON, pool_g[pick], pool_c[pick], pool_n[pick]);
          open_keys.insert(open_keys.size(), pick);
        end
      end
      send_report();
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_pairing_basics();
    test_entry_repeat_hits();
    test_output_backpressure();
    test_random_clips();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
